[design/pidc_pkg.sv]
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared constants, types and the term schedule of the two-mode PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF    = 8;

  localparam int GAIN_W   = 16;
  localparam int WEIGHT_W = 9;
  localparam int DRIVE_W  = 32;
  localparam int STATE_W  = 32;

  // digit-serial multiplier: unsigned 16-bit multiplier, 4-bit digits
  localparam int MULT_W    = 16;
  localparam int DIGIT_W   = 4;
  localparam int DIGITS    = MULT_W / DIGIT_W;
  localparam int DIG_CNT_W = $clog2(DIGITS + 1);

  localparam logic [MULT_W-1:0]   SMOOTH_OLD = 16'd58982;  // 0.9 in Q0.16
  localparam logic [MULT_W-1:0]   SMOOTH_NEW = 16'd6554;   // 0.1 in Q0.16
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;     // 1.0 in Q0.8

  localparam int FD_SHIFT     = 8;
  localparam int SMOOTH_SHIFT = 16;

  localparam logic MODE_POSITIONAL  = 1'b0;
  localparam logic MODE_INCREMENTAL = 1'b1;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MODE         = 3'd0,
    REG_GAIN_P       = 3'd1,
    REG_GAIN_I       = 3'd2,
    REG_GAIN_D       = 3'd3,
    REG_DERIV_WEIGHT = 3'd4
  } cfg_reg_t;

  localparam logic [GAIN_W-1:0]   GAIN_P_RST       = 16'd512;
  localparam logic [GAIN_W-1:0]   GAIN_I_RST       = 16'd0;
  localparam logic [GAIN_W-1:0]   GAIN_D_RST       = 16'd1280;
  localparam logic [WEIGHT_W-1:0] DERIV_WEIGHT_RST = 9'd205;

  // multiply-accumulate schedule
  localparam int TERM_W = 3;

  typedef enum logic [2:0] {
    MC_D_SHIFT,    // (e - prior) in fraction units
    MC_FD,         // filtered derivative
    MC_E_SHIFT,    // e in fraction units
    MC_E_MINUS_L,  // ef - L
    MC_E_SECOND,   // ef - 2L + P
    MC_L,
    MC_P
  } mc_sel_t;

  typedef enum logic [2:0] {
    ML_WEIGHT,
    ML_WEIGHT_COMP,
    ML_KP,
    ML_KI,
    ML_KD,
    ML_OLD,
    ML_NEW
  } ml_sel_t;

  typedef enum logic [2:0] {
    POST_NONE,
    POST_FD,
    POST_DRIVE,
    POST_PREV,
    POST_LAST
  } post_t;

  typedef struct packed {
    mc_sel_t mc;
    ml_sel_t ml;
    logic    clear;
    post_t   post;
    logic    last;
  } term_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic  capture;
    logic  load;
    logic  apply;
    logic  out_load;
    term_t term;
  } ctl_t;

  function automatic term_t term_lookup(input logic mode, input logic [TERM_W-1:0] idx);
    term_t t;
    t = '{mc: MC_FD, ml: ML_KD, clear: 1'b0, post: POST_NONE, last: 1'b1};
    if (mode == MODE_POSITIONAL) begin
      unique case (idx)
        3'd0:    t = '{mc: MC_D_SHIFT, ml: ML_WEIGHT,      clear: 1'b1,
                       post: POST_NONE,  last: 1'b0};
        3'd1:    t = '{mc: MC_FD,      ml: ML_WEIGHT_COMP, clear: 1'b0,
                       post: POST_FD,    last: 1'b0};
        3'd2:    t = '{mc: MC_E_SHIFT, ml: ML_KP,          clear: 1'b1,
                       post: POST_NONE,  last: 1'b0};
        3'd3:    t = '{mc: MC_FD,      ml: ML_KD,          clear: 1'b0,
                       post: POST_DRIVE, last: 1'b1};
        default: t = '{mc: MC_FD,      ml: ML_KD,          clear: 1'b0,
                       post: POST_NONE,  last: 1'b1};
      endcase
    end else begin
      unique case (idx)
        3'd0:    t = '{mc: MC_E_MINUS_L, ml: ML_KP,  clear: 1'b1,
                       post: POST_NONE,  last: 1'b0};
        3'd1:    t = '{mc: MC_E_SHIFT,   ml: ML_KI,  clear: 1'b0,
                       post: POST_NONE,  last: 1'b0};
        3'd2:    t = '{mc: MC_E_SECOND,  ml: ML_KD,  clear: 1'b0,
                       post: POST_DRIVE, last: 1'b0};
        3'd3:    t = '{mc: MC_L,         ml: ML_OLD, clear: 1'b1,
                       post: POST_NONE,  last: 1'b0};
        3'd4:    t = '{mc: MC_P,         ml: ML_NEW, clear: 1'b0,
                       post: POST_PREV,  last: 1'b0};
        3'd5:    t = '{mc: MC_E_SHIFT,   ml: ML_OLD, clear: 1'b1,
                       post: POST_NONE,  last: 1'b0};
        3'd6:    t = '{mc: MC_L,         ml: ML_NEW, clear: 1'b0,
                       post: POST_LAST,  last: 1'b1};
        default: t = '{mc: MC_FD,        ml: ML_KD,  clear: 1'b0,
                       post: POST_NONE,  last: 1'b1};
      endcase
    end
    return t;
  endfunction

endpackage

[design/pidc_if.sv]
// ----------------------------------------------------------------------------
// pidc_if
// Valid/ready channels of the PID controller: sample in, drive out.
// ----------------------------------------------------------------------------
interface pidc_sample_if #(
  parameter int SAMPLE_WIDTH = pidc_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] measured;
  logic signed [SAMPLE_WIDTH-1:0] target;

  modport source (output valid, measured, target, input ready);
  modport sink   (input valid, measured, target, output ready);
endinterface

interface pidc_drive_if;
  import pidc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;

  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

[design/pidc_mac.sv]
// ----------------------------------------------------------------------------
// pidc_mac
// Digit-serial multiply-accumulate: one 4-bit digit of the unsigned
// multiplier per cycle, multiplicand shifted up a digit each step.
// ----------------------------------------------------------------------------
module pidc_mac #(
  parameter int MC_W  = 38,
  parameter int ACC_W = 56
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic                          clear,
  input  logic signed [MC_W-1:0]        mcand,
  input  logic [pidc_pkg::MULT_W-1:0]   mult,
  output logic                          busy,
  output logic signed [ACC_W-1:0]       acc
);
  import pidc_pkg::*;

  logic signed [ACC_W-1:0]         mc_sh;
  logic [MULT_W-1:0]               mul_sh;
  logic [DIG_CNT_W-1:0]            cnt;
  logic signed [ACC_W+DIGIT_W:0]   pp;

  assign busy = (cnt != '0);
  assign pp   = mc_sh * $signed({1'b0, mul_sh[DIGIT_W-1:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= DIG_CNT_W'(DIGITS);
    end else if (busy) begin
      cnt <= cnt - DIG_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mc_sh  <= ACC_W'(mcand);
      mul_sh <= mult;
      if (clear) begin
        acc <= '0;
      end
    end else if (busy) begin
      acc    <= acc + $signed(pp[ACC_W-1:0]);
      mc_sh  <= mc_sh <<< DIGIT_W;
      mul_sh <= mul_sh >> DIGIT_W;
    end
  end

endmodule

[design/pidc_ctrl.sv]
// ----------------------------------------------------------------------------
// pidc_ctrl
// Sequencer: steps through the multiply-accumulate terms of the active mode
// and hands each finished sum to the datapath.
// ----------------------------------------------------------------------------
module pidc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            mode,
  input  logic            sample_valid,
  input  logic            mac_busy,
  input  logic            out_free,
  output logic            sample_ready,
  output pidc_pkg::ctl_t  ctl
);
  import pidc_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [TERM_W-1:0]   idx;
  logic [TERM_W-1:0]   idx_next;
  term_t               term;

  assign term = term_lookup(mode, idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      ST_IDLE: begin
        idx_next = '0;
        if (sample_valid) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (!mac_busy) begin
          if (term.last) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_LOAD;
            idx_next   = idx + TERM_W'(1);
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample_ready = (state == ST_IDLE);
    ctl.capture  = (state == ST_IDLE) && sample_valid;
    ctl.load     = (state == ST_LOAD);
    ctl.apply    = (state == ST_RUN) && !mac_busy;
    ctl.out_load = (state == ST_OUT) && out_free;
    ctl.term     = term;
  end

endmodule

[design/pid_controller_two_mode.sv]
// ----------------------------------------------------------------------------
// pid_controller_two_mode
// Two-mode fixed-point PID controller: positional PD with a filtered
// derivative, or incremental PID with smoothed error histories.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  sample   in   valid/ready        measured, target (signed SAMPLE_WIDTH)
//  result   out  valid/ready        drive (signed 32, 1/256 units)
//  cfg      in   cfg_we, no stall   cfg_index, cfg_data
//
//  One item is one digit-serial multiply-accumulate pass per term, each term a
//  load step and then the digit steps; a sample takes 4 terms in positional
//  mode and 7 in incremental mode, and is finished before the next is accepted.
//  A new sample is taken while an earlier drive still waits in the output
//  register; the result waits in its own state if that register is still full.
//  Synchronous reset clears the controller state and loads the register defaults.
// ----------------------------------------------------------------------------
module pid_controller_two_mode #(
  parameter int SAMPLE_WIDTH = pidc_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = pidc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pidc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pidc_pkg::CFG_DATA_W-1:0]   cfg_data,
  pidc_sample_if.sink                       sample,
  pidc_drive_if.source                      result
);
  import pidc_pkg::*;

  localparam int E_W   = SAMPLE_WIDTH + 1;
  localparam int D_W   = SAMPLE_WIDTH + 2;
  localparam int MC_W  = (((D_W + FRAC_BITS) > STATE_W) ? (D_W + FRAC_BITS) : STATE_W) + 3;
  localparam int ACC_W = MC_W + MULT_W + 2;
  localparam int RND_W = ACC_W + 1;

  localparam logic signed [RND_W-1:0] SAT_HI = (RND_W'(1) <<< (STATE_W - 1)) - RND_W'(1);
  localparam logic signed [RND_W-1:0] SAT_LO = -(RND_W'(1) <<< (STATE_W - 1));

  // configuration registers
  logic                 cfg_mode;
  logic [GAIN_W-1:0]    gain_p;
  logic [GAIN_W-1:0]    gain_i;
  logic [GAIN_W-1:0]    gain_d;
  logic [WEIGHT_W-1:0]  deriv_weight;

  // controller state
  logic signed [E_W-1:0]      prior_error;
  logic signed [STATE_W-1:0]  filtered_deriv;
  logic signed [STATE_W-1:0]  smoothed_last_error;
  logic signed [STATE_W-1:0]  smoothed_prev_error;

  logic signed [E_W-1:0]      err;
  logic signed [DRIVE_W-1:0]  drive_res;
  logic                       out_valid;
  logic signed [DRIVE_W-1:0]  out_drive;

  ctl_t                       ctl;
  logic                       sample_ready;
  logic                       out_free;
  logic                       mac_busy;
  logic signed [ACC_W-1:0]    acc;

  logic signed [D_W-1:0]      d_int;
  logic signed [MC_W-1:0]     ef;
  logic signed [MC_W-1:0]     mcand;
  logic [MULT_W-1:0]          mult;
  logic [WEIGHT_W-1:0]        w_eff;
  logic [WEIGHT_W-1:0]        w_comp;

  logic signed [RND_W-1:0]    rnd_fd;
  logic signed [RND_W-1:0]    rnd_frac;
  logic signed [RND_W-1:0]    rnd_smooth;

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [RND_W-1:0] x);
    logic signed [STATE_W-1:0] r;
    if (x > SAT_HI) begin
      r = SAT_HI[STATE_W-1:0];
    end else if (x < SAT_LO) begin
      r = SAT_LO[STATE_W-1:0];
    end else begin
      r = x[STATE_W-1:0];
    end
    return r;
  endfunction

  // -- configuration --------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mode     <= MODE_POSITIONAL;
      gain_p       <= GAIN_P_RST;
      gain_i       <= GAIN_I_RST;
      gain_d       <= GAIN_D_RST;
      deriv_weight <= DERIV_WEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:         cfg_mode     <= cfg_data[0];
        REG_GAIN_P:       gain_p       <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:       gain_i       <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:       gain_d       <= cfg_data[GAIN_W-1:0];
        REG_DERIV_WEIGHT: deriv_weight <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // -- sequencer and serial MAC ---------------------------------------------
  assign out_free     = !out_valid || result.ready;
  assign sample.ready = sample_ready;

  pidc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .mode         (cfg_mode),
    .sample_valid (sample.valid),
    .mac_busy     (mac_busy),
    .out_free     (out_free),
    .sample_ready (sample_ready),
    .ctl          (ctl)
  );

  pidc_mac #(
    .MC_W  (MC_W),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk   (clk),
    .rst   (rst),
    .load  (ctl.load),
    .clear (ctl.term.clear),
    .mcand (mcand),
    .mult  (mult),
    .busy  (mac_busy),
    .acc   (acc)
  );

  // -- operand selection ----------------------------------------------------
  assign d_int  = D_W'(err) - D_W'(prior_error);
  assign ef     = MC_W'(err) <<< FRAC_BITS;
  assign w_eff  = (deriv_weight > WEIGHT_ONE) ? WEIGHT_ONE : deriv_weight;
  assign w_comp = WEIGHT_ONE - w_eff;

  always_comb begin
    unique case (ctl.term.mc)
      MC_D_SHIFT:   mcand = MC_W'(d_int) <<< FRAC_BITS;
      MC_FD:        mcand = MC_W'(filtered_deriv);
      MC_E_SHIFT:   mcand = ef;
      MC_E_MINUS_L: mcand = ef - MC_W'(smoothed_last_error);
      MC_E_SECOND:  mcand = ef - (MC_W'(smoothed_last_error) <<< 1)
                               + MC_W'(smoothed_prev_error);
      MC_L:         mcand = MC_W'(smoothed_last_error);
      MC_P:         mcand = MC_W'(smoothed_prev_error);
      default:      mcand = '0;
    endcase
  end

  always_comb begin
    unique case (ctl.term.ml)
      ML_WEIGHT:      mult = MULT_W'(w_eff);
      ML_WEIGHT_COMP: mult = MULT_W'(w_comp);
      ML_KP:          mult = gain_p;
      ML_KI:          mult = gain_i;
      ML_KD:          mult = gain_d;
      ML_OLD:         mult = SMOOTH_OLD;
      ML_NEW:         mult = SMOOTH_NEW;
      default:        mult = '0;
    endcase
  end

  // -- round to nearest (ties up) of the finished sum -----------------------
  assign rnd_fd     = (RND_W'(acc) + (RND_W'(1) <<< (FD_SHIFT - 1))) >>> FD_SHIFT;
  assign rnd_frac   = (RND_W'(acc) + (RND_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  assign rnd_smooth = (RND_W'(acc) + (RND_W'(1) <<< (SMOOTH_SHIFT - 1))) >>> SMOOTH_SHIFT;

  // -- datapath registers ---------------------------------------------------
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      err <= E_W'(sample.target) - E_W'(sample.measured);
    end
    if (ctl.apply && (ctl.term.post == POST_DRIVE)) begin
      drive_res <= sat_state(rnd_frac);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_error         <= '0;
      filtered_deriv      <= '0;
      smoothed_last_error <= '0;
      smoothed_prev_error <= '0;
    end else if (ctl.apply) begin
      unique case (ctl.term.post)
        POST_NONE: ;
        POST_FD: begin
          filtered_deriv <= sat_state(rnd_fd);
          prior_error    <= err;
        end
        POST_DRIVE: ;
        POST_PREV: smoothed_prev_error <= sat_state(rnd_smooth);
        POST_LAST: smoothed_last_error <= sat_state(rnd_smooth);
        default: ;
      endcase
    end
  end

  // -- output register ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_drive <= drive_res;
    end
  end

  assign result.valid = out_valid;
  assign result.drive = out_drive;

endmodule
